>>> sv/bidebc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidebc_pkg
// shared constants and types for the button id entry and blink code block
// ----------------------------------------------------------------------------
package bidebc_pkg;

    localparam int ID_LIMIT     = 16;
    localparam int HOLD_TICKS   = 300;
    localparam int RELEASE_WAIT = 300;
    localparam int PRESS_WAIT   = 1000;
    localparam int BLINK_TICKS  = 20;
    localparam int SLEEP_TICKS  = 100;
    localparam int PAUSE_TICKS  = SLEEP_TICKS + BLINK_TICKS;
    localparam int DIVIDER_LOAD = 10;

    localparam int HOLD_W  = 9;
    localparam int COUNT_W = 8;
    localparam int DEAD_W  = 10;
    localparam int DIV_W   = 4;
    localparam int BLINK_W = 10;
    localparam int ID_W    = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [0:0] {
        CFG_ID_KNOWN  = 1'b0,
        CFG_ID_NUMBER = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic            id_led;
        logic            tx_led;
        logic            rx_led;
        logic            entry_active;
        logic            commit_valid;
        logic [ID_W-1:0] commit_id;
    } result_t;

endpackage

>>> sv/button_id_entry_and_blink_code.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_id_entry_and_blink_code
// button driven node id entry with id blink code, one transaction per tick
//
// input channel (in_valid/in_ready) carries one 10 ms tick: safety_on and
// the raw button level. output channel (out_valid/out_ready) returns one
// result per tick: the three led drives, entry_active and a commit strobe
// with the committed id.
// path: a transaction lands in the input register, the tick is evaluated
// against the block state when it advances and is written to the result
// register, from which its result is offered.
// throughput: one transaction per cycle while the result register is free
// or taken, as the state update is combinational between the two registers.
// when the receiver stalls the result register holds, and the input
// register holds one more transaction before in_ready drops.
// reset clears both stages, the debouncer, the entry logic and the led
// state; id_known and id_number reset to 0 and are written on the cfg port.
// ----------------------------------------------------------------------------
module button_id_entry_and_blink_code (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        safety_on,
    input  logic                        button_raw,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        id_led,
    output logic                        tx_led,
    output logic                        rx_led,
    output logic                        entry_active,
    output logic                        commit_valid,
    output logic [bidebc_pkg::ID_W-1:0] commit_id,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [bidebc_pkg::ID_W-1:0] cfg_wdata
);
    import bidebc_pkg::*;

    logic            s1_valid_reg;
    logic            safety_reg;
    logic            button_reg;
    logic            out_valid_reg;
    result_t         result_reg;
    result_t         res;
    logic            advance;
    logic            id_known_reg;
    logic [ID_W-1:0] id_number_reg;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_known_reg  <= 1'b0;
            id_number_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ID_KNOWN:  id_known_reg  <= cfg_wdata[0];
                CFG_ID_NUMBER: id_number_reg <= cfg_wdata;
                default:       id_known_reg  <= id_known_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            safety_reg <= safety_on;
            button_reg <= button_raw;
        end
        if (advance)
            result_reg <= res;
    end

    bidebc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .safety_on  (safety_reg),
        .button_raw (button_reg),
        .id_known   (id_known_reg),
        .id_number  (id_number_reg),
        .res        (res)
    );

    assign out_valid    = out_valid_reg;
    assign id_led       = result_reg.id_led;
    assign tx_led       = result_reg.tx_led;
    assign rx_led       = result_reg.rx_led;
    assign entry_active = result_reg.entry_active;
    assign commit_valid = result_reg.commit_valid;
    assign commit_id    = result_reg.commit_id;

`ifndef SYNTHESIS
    a_commit_ends_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && commit_valid |-> !entry_active)
        else $error("commit while entry mode still active");

    a_commit_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !commit_valid |-> commit_id == '0)
        else $error("commit id nonzero without commit");

    a_entry_antiphase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_active |-> tx_led != rx_led)
        else $error("tx and rx not in antiphase during entry");

    a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_active |-> !tx_led && !rx_led)
        else $error("tx or rx lit outside entry mode");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule

>>> sv/bidebc_blink.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidebc_blink
// id blink code: led phase and blink tick counter update for one tick
// ----------------------------------------------------------------------------
module bidebc_blink (
    input  logic                       id_known,
    input  logic [bidebc_pkg::ID_W-1:0]    id_number,
    input  logic [bidebc_pkg::BLINK_W-1:0] blink_ticks,
    input  logic                       led_in,
    output logic                       led_out,
    output logic [bidebc_pkg::BLINK_W-1:0] blink_next
);
    import bidebc_pkg::*;

    logic [BLINK_W-3:0] quarter;
    logic [17:0]        prod;
    logic [7:0]         quot;
    logic [BLINK_W-3:0] back;
    logic               multiple;
    logic [BLINK_W-1:0] reload;

    // blink_ticks % 20 == 0 as low two bits zero and quarter divisible by 5
    assign quarter  = blink_ticks[BLINK_W-1:2];
    assign prod     = 18'(quarter) * 18'd205;
    assign quot     = prod[17:10];
    assign back     = quot * 8'd5;
    assign multiple = (blink_ticks[1:0] == 2'b00) && (back == quarter);
    assign reload   = (BLINK_W'(id_number) + BLINK_W'(1)) * BLINK_W'(2 * BLINK_TICKS)
                      + BLINK_W'(PAUSE_TICKS);

    always_comb
    begin
        led_out    = led_in;
        blink_next = blink_ticks;
        if (!id_known)
        begin
            led_out = 1'b1;
        end
        else
        begin
            if (blink_ticks <= BLINK_W'(PAUSE_TICKS))
                led_out = 1'b0;
            else if (multiple)
                led_out = ~led_in;
            if (blink_ticks == '0)
                blink_next = reload;
            else
                blink_next = blink_ticks - BLINK_W'(1);
        end
    end

endmodule

>>> sv/bidebc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidebc_core
// debouncer, hold detect, entry mode and led state, one tick per step
// ----------------------------------------------------------------------------
module bidebc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        safety_on,
    input  logic                        button_raw,
    input  logic                        id_known,
    input  logic [bidebc_pkg::ID_W-1:0] id_number,
    output bidebc_pkg::result_t         res
);
    import bidebc_pkg::*;

    logic               deb_first_reg, deb_first_next;
    logic               deb_second_reg, deb_second_next;
    logic [HOLD_W-1:0]  hold_reg, hold_next;
    logic               entry_reg, entry_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               seen_reg, seen_next;
    logic [DEAD_W-1:0]  dead_reg, dead_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [BLINK_W-1:0] blink_reg, blink_next;
    logic               id_led_reg, id_led_next;
    logic               tx_reg, tx_next;
    logic               rx_reg, rx_next;

    logic               pressed;
    logic               blink_led_in;
    logic               blink_led_out;
    logic [BLINK_W-1:0] blink_cnt_out;
    logic [HOLD_W-1:0]  hold_inc;

    bidebc_blink u_blink (
        .id_known    (id_known),
        .id_number   (id_number),
        .blink_ticks (blink_reg),
        .led_in      (blink_led_in),
        .led_out     (blink_led_out),
        .blink_next  (blink_cnt_out)
    );

    // debouncer
    always_comb
    begin
        deb_first_next  = deb_first_reg;
        deb_second_next = deb_second_reg;
        pressed         = 1'b0;
        if (!button_raw)
        begin
            if (deb_first_reg || deb_second_reg)
            begin
                deb_second_next = 1'b1;
                pressed         = 1'b1;
            end
            else
            begin
                deb_first_next = 1'b1;
            end
        end
        else if (!deb_first_reg)
        begin
            deb_second_next = 1'b0;
        end
        else
        begin
            deb_first_next = 1'b0;
            pressed        = deb_second_reg;
        end
    end

    assign hold_inc = (hold_reg < HOLD_W'(HOLD_TICKS)) ? hold_reg + HOLD_W'(1) : hold_reg;
    assign blink_led_in = (!entry_reg && safety_on && pressed
                           && hold_inc >= HOLD_W'(HOLD_TICKS)) ? 1'b0 : id_led_reg;

    always_comb
    begin
        hold_next        = hold_reg;
        entry_next       = entry_reg;
        count_next       = count_reg;
        seen_next        = seen_reg;
        dead_next        = dead_reg;
        div_next         = div_reg;
        blink_next       = blink_reg;
        id_led_next      = id_led_reg;
        tx_next          = tx_reg;
        rx_next          = rx_reg;
        res.commit_valid = 1'b0;
        res.commit_id    = '0;
        if (entry_reg)
        begin
            if (dead_reg == '0)
            begin
                entry_next = 1'b0;
                tx_next    = 1'b0;
                rx_next    = 1'b0;
                if (count_reg >= COUNT_W'(1) && count_reg < COUNT_W'(ID_LIMIT))
                begin
                    res.commit_valid = 1'b1;
                    res.commit_id    = ID_W'(count_reg - COUNT_W'(1));
                end
                count_next  = '0;
                seen_next   = 1'b0;
                id_led_next = blink_led_out;
                blink_next  = blink_cnt_out;
            end
            else
            begin
                dead_next = dead_reg - DEAD_W'(1);
                if (pressed && !seen_reg)
                begin
                    if (count_reg != COUNT_MAX)
                        count_next = count_reg + COUNT_W'(1);
                    id_led_next = 1'b1;
                    seen_next   = 1'b1;
                    dead_next   = DEAD_W'(PRESS_WAIT);
                end
                else if (!pressed && seen_reg)
                begin
                    id_led_next = 1'b0;
                    seen_next   = 1'b0;
                    dead_next   = DEAD_W'(RELEASE_WAIT);
                end
                if (div_reg == '0)
                begin
                    tx_next  = ~tx_reg;
                    rx_next  = ~rx_reg;
                    div_next = DIV_W'(DIVIDER_LOAD);
                end
                else
                begin
                    div_next = div_reg - DIV_W'(1);
                end
            end
        end
        else if (safety_on && pressed)
        begin
            hold_next   = hold_inc;
            id_led_next = blink_led_out;
            blink_next  = blink_cnt_out;
        end
        else if (safety_on && hold_reg >= HOLD_W'(HOLD_TICKS))
        begin
            hold_next   = '0;
            entry_next  = 1'b1;
            count_next  = '0;
            seen_next   = 1'b0;
            dead_next   = DEAD_W'(RELEASE_WAIT);
            div_next    = DIV_W'(DIVIDER_LOAD);
            tx_next     = 1'b1;
            rx_next     = 1'b0;
            id_led_next = 1'b0;
        end
        else
        begin
            hold_next   = '0;
            id_led_next = blink_led_out;
            blink_next  = blink_cnt_out;
        end
        res.id_led       = id_led_next;
        res.tx_led       = tx_next;
        res.rx_led       = rx_next;
        res.entry_active = entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_first_reg  <= 1'b0;
            deb_second_reg <= 1'b0;
            hold_reg       <= '0;
            entry_reg      <= 1'b0;
            count_reg      <= '0;
            seen_reg       <= 1'b0;
            dead_reg       <= '0;
            div_reg        <= DIV_W'(DIVIDER_LOAD);
            blink_reg      <= '0;
            id_led_reg     <= 1'b0;
            tx_reg         <= 1'b0;
            rx_reg         <= 1'b0;
        end
        else if (step)
        begin
            deb_first_reg  <= deb_first_next;
            deb_second_reg <= deb_second_next;
            hold_reg       <= hold_next;
            entry_reg      <= entry_next;
            count_reg      <= count_next;
            seen_reg       <= seen_next;
            dead_reg       <= dead_next;
            div_reg        <= div_next;
            blink_reg      <= blink_next;
            id_led_reg     <= id_led_next;
            tx_reg         <= tx_next;
            rx_reg         <= rx_next;
        end
    end

endmodule

>>> verif/tb_button_id_entry_and_blink_code.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_id_entry_and_blink_code
// self-checking bench for the button id entry and blink code block
//
// a clocked driver feeds 10 ms ticks from a queue and predicts each tick's
// led, entry and commit outputs; a clocked monitor compares every result
// transaction field by field against the oldest prediction. stimulus is a
// short directed run of debouncer corner cases, then long hold and press
// sequences with random content, under changing id settings, random
// backpressure and a long receiver stall.
// ----------------------------------------------------------------------------
module tb_button_id_entry_and_blink_code;

    import bidebc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic safety;
        logic button;
    } tick_t;

    // {safety, button} pairs, leftmost goes first
    localparam logic [49:0] DIRECTED_TICKS = {
        2'b01, 2'b11, 2'b00, 2'b10, 2'b11, 2'b11, 2'b10, 2'b11, 2'b11,
        2'b10, 2'b10, 2'b10, 2'b11, 2'b11, 2'b00, 2'b00, 2'b01, 2'b01,
        2'b10, 2'b11, 2'b10, 2'b10, 2'b11, 2'b10, 2'b11
    };

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic                safety_on    = 1'b0;
    logic                button_raw   = 1'b1;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic                id_led;
    logic                tx_led;
    logic                rx_led;
    logic                entry_active;
    logic                commit_valid;
    logic [ID_W-1:0]     commit_id;
    logic                cfg_we       = 1'b0;
    logic                cfg_index    = 1'b0;
    logic [ID_W-1:0]     cfg_wdata    = '0;

    tick_t               tick_queue[$];
    result_t             expected_results[$];
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    logic                hold_go       = 1'b0;
    logic                hold_done;
    int                  hold_left;
    int                  fault_count   = 0;
    int                  result_index  = 0;
    int                  cycle_count   = 0;
    tick_t               next_tick;
    result_t             predicted;
    result_t             wanted;
    result_t             seen;

    // predictor state and its copy of the id registers
    logic                known_cfg  = 1'b0;
    logic [ID_W-1:0]     number_cfg = '0;
    logic                db_a;
    logic                db_b;
    logic [HOLD_W-1:0]   hold_cnt;
    logic                entry_on;
    logic [COUNT_W-1:0]  presses;
    logic                down_seen;
    logic [DEAD_W-1:0]   deadline;
    logic [DIV_W-1:0]    toggle_cnt;
    logic [BLINK_W-1:0]  blink_cnt;
    logic                led_id;
    logic                led_tx;
    logic                led_rx;

    button_id_entry_and_blink_code DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .safety_on    (safety_on),
        .button_raw   (button_raw),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .id_led       (id_led),
        .tx_led       (tx_led),
        .rx_led       (rx_led),
        .entry_active (entry_active),
        .commit_valid (commit_valid),
        .commit_id    (commit_id),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic advance_blink();
        if (!known_cfg)
        begin
            led_id = 1'b1;
        end
        else
        begin
            if (blink_cnt <= PAUSE_TICKS)
                led_id = 1'b0;
            else if ((blink_cnt % BLINK_TICKS) == 0)
                led_id = ~led_id;
            if (blink_cnt == '0)
                blink_cnt = BLINK_W'((int'(number_cfg) + 1) * 2 * BLINK_TICKS + PAUSE_TICKS);
            else
                blink_cnt = blink_cnt - 1'b1;
        end
    endtask

    task automatic step_button_logic(input tick_t t, output result_t r);
        logic down;
        logic reload;
        r = '0;
        // two-flag debouncer, button low means pressed
        if (!t.button)
        begin
            down = db_a || db_b;
            if (down)
                db_b = 1'b1;
            else
                db_a = 1'b1;
        end
        else
        begin
            down = db_a && db_b;
            if (!db_a)
                db_b = 1'b0;
            else
                db_a = 1'b0;
        end

        if (entry_on)
        begin
            if (deadline == '0)
            begin
                entry_on = 1'b0;
                led_tx   = 1'b0;
                led_rx   = 1'b0;
                if (presses >= 1 && presses < ID_LIMIT)
                begin
                    r.commit_valid = 1'b1;
                    r.commit_id    = presses[ID_W-1:0] - 1'b1;
                end
                presses   = '0;
                down_seen = 1'b0;
                advance_blink();
            end
            else
            begin
                reload = 1'b0;
                if (down && !down_seen)
                begin
                    if (presses != COUNT_MAX)
                        presses = presses + 1'b1;
                    led_id    = 1'b1;
                    down_seen = 1'b1;
                    deadline  = DEAD_W'(PRESS_WAIT);
                    reload    = 1'b1;
                end
                if (!down && down_seen)
                begin
                    led_id    = 1'b0;
                    down_seen = 1'b0;
                    deadline  = DEAD_W'(RELEASE_WAIT);
                    reload    = 1'b1;
                end
                if (!reload)
                    deadline = deadline - 1'b1;
                if (toggle_cnt == '0)
                begin
                    led_tx     = ~led_tx;
                    led_rx     = ~led_rx;
                    toggle_cnt = DIV_W'(DIVIDER_LOAD);
                end
                else
                begin
                    toggle_cnt = toggle_cnt - 1'b1;
                end
            end
        end
        else if (t.safety && down)
        begin
            if (hold_cnt < HOLD_TICKS)
                hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt >= HOLD_TICKS)
                led_id = 1'b0;
            advance_blink();
        end
        else if (t.safety && hold_cnt >= HOLD_TICKS)
        begin
            hold_cnt   = '0;
            entry_on   = 1'b1;
            presses    = '0;
            down_seen  = 1'b0;
            deadline   = DEAD_W'(RELEASE_WAIT);
            toggle_cnt = DIV_W'(DIVIDER_LOAD);
            led_tx     = 1'b1;
            led_rx     = 1'b0;
            led_id     = 1'b0;
        end
        else
        begin
            hold_cnt = '0;
            advance_blink();
        end

        r.id_led       = led_id;
        r.tx_led       = led_tx;
        r.rx_led       = led_rx;
        r.entry_active = entry_on;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            safety_on  <= 1'b0;
            button_raw <= 1'b1;
            db_a       = 1'b0;
            db_b       = 1'b0;
            hold_cnt   = '0;
            entry_on   = 1'b0;
            presses    = '0;
            down_seen  = 1'b0;
            deadline   = '0;
            toggle_cnt = DIV_W'(DIVIDER_LOAD);
            blink_cnt  = '0;
            led_id     = 1'b0;
            led_tx     = 1'b0;
            led_rx     = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                step_button_logic({safety_on, button_raw}, predicted);
                expected_results.push_back(predicted);
            end
            if (!in_valid || in_ready)
            begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_tick = tick_queue.pop_front();
                    in_valid   <= 1'b1;
                    safety_on  <= next_tick.safety;
                    button_raw <= next_tick.button;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {id_led, tx_led, rx_led, entry_active, commit_valid, commit_id};
                if (expected_results.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected result transaction %0d: %b", result_index, seen);
                    fault_count = fault_count + 1;
                end
                else
                begin
                    wanted = expected_results.pop_front();
                    if (seen.id_led !== wanted.id_led || seen.tx_led !== wanted.tx_led
                        || seen.rx_led !== wanted.rx_led
                        || seen.entry_active !== wanted.entry_active
                        || seen.commit_valid !== wanted.commit_valid
                        || seen.commit_id !== wanted.commit_id)
                    begin
                        if (fault_count < 10)
                            $display("mismatch at result %0d: expected %b, got %b",
                                     result_index, wanted, seen);
                        fault_count = fault_count + 1;
                    end
                end
                result_index = result_index + 1;
            end

            // one long stall so the block backs up its input
            if (hold_go && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= 200;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL button_id_entry_and_blink_code");
            $finish;
        end
    end

    task automatic add_ticks(input int count, input logic safety, input logic button);
        tick_t t;
        t.safety = safety;
        t.button = button;
        repeat (count) tick_queue.push_back(t);
    endtask

    task automatic add_noise(input int count);
        repeat (count) add_ticks(1, 1'($urandom_range(1)), $urandom_range(99) >= 15);
    endtask

    // clean debouncer, hold with safety on, then release
    task automatic add_hold(input int hold_len);
        add_ticks(2, 1'b0, 1'b1);
        add_ticks(hold_len, 1'b1, 1'b0);
        add_ticks(2, 1'b1, 1'b1);
    endtask

    task automatic add_id_entry(input int hold_len, input int press_total,
                                input logic hold_last, input logic quick);
        int down_len;
        int up_len;
        add_hold(hold_len);
        for (int i = 0; i < press_total; i++)
        begin
            down_len = quick ? 2 : $urandom_range(6, 2);
            if (hold_last && i == press_total - 1)
                down_len = 1010;
            up_len = quick ? 2 : $urandom_range(30, 2);
            repeat (down_len) add_ticks(1, 1'($urandom_range(1)), 1'b0);
            for (int k = 0; k < up_len; k++)
                add_ticks(1, 1'($urandom_range(1)), !(k >= 2 && $urandom_range(15) == 0));
        end
        if (!hold_last || press_total == 0)
            repeat (305 + $urandom_range(15)) add_ticks(1, 1'($urandom_range(1)), 1'b1);
        add_noise($urandom_range(60, 20));
    endtask

    task automatic wait_idle();
        while (tick_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [ID_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ID_KNOWN)
            known_cfg = val[0];
        else
            number_cfg = val;
    endtask

    initial
    begin
        while (!rst_n) @(posedge clk);

        send_idle_pct = 34;
        recv_idle_pct = 80;
        for (int i = 24; i >= 0; i--)
            tick_queue.push_back(tick_t'(DIRECTED_TICKS[2*i +: 2]));
        wait_idle();

        write_reg(CFG_ID_KNOWN, ID_W'(1));
        write_reg(CFG_ID_NUMBER, '0);
        add_id_entry(300, 1, 1'b0, 1'b0);
        wait_idle();

        send_idle_pct = 80;
        recv_idle_pct = 34;
        write_reg(CFG_ID_NUMBER, ID_W'(15));
        // press count at or above the id limit commits nothing
        add_id_entry(300 + $urandom_range(20), 16 + $urandom_range(2), 1'b0, 1'b1);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_ID_KNOWN, '0);
        write_reg(CFG_ID_NUMBER, ID_W'($urandom_range(14, 1)));
        // hold one tick short of entry
        add_hold(299);
        add_noise(40);
        @(posedge clk);
        hold_go <= 1'b1;
        wait_idle();

        repeat (10) @(posedge clk);
        if (fault_count == 0 && expected_results.size() == 0)
            $display("PASS button_id_entry_and_blink_code");
        else
            $display("FAIL button_id_entry_and_blink_code");
        $finish;
    end

endmodule
